[rtl/pfl_pkg.sv]
// Shared constants, types and codes for the page free-list allocator.
package pfl_pkg;

  localparam int PAGE_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int CHK_W       = COUNT_W + 1;
  localparam int MAX_PAGES   = 1024;
  localparam int GROW_PAGES  = 10;
  localparam int LINK_AW     = $clog2(MAX_PAGES);
  localparam int GROW_CW     = $clog2(GROW_PAGES + 1);
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int STATUS_W    = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_HEAD  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GROW,
    S_READ,
    S_POP,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ADDR_HEAD,
    ADDR_PAGE,
    ADDR_GROW
  } addr_sel_e;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic cmd_free;
    logic head_zero;
    logic full;
    logic out_of_range;
    logic is_head;
    logic grow_last;
    logic out_free;
  } flags_t;

  // sequencer controls for the datapath
  typedef struct packed {
    logic      accept;
    addr_sel_e addr_sel;
    logic      ram_we;
    logic      wdata_grow;
    logic      grow_start;
    logic      grow_step;
    logic      grow_commit;
    logic      head_from_ram;
    logic      head_from_page;
    logic      res_load;
    logic      res_page_head;
    status_e   res_status;
    logic      out_load;
  } ctrl_t;

endpackage

[rtl/pfl_ram.sv]
// Generic single-port RAM with registered read data.
module pfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pfl_seq.sv]
// Sequencer: steps one request through decode, chunk growth, link read and result.
module pfl_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  pfl_pkg::flags_t flags_i,
  output logic            in_ready_o,
  output pfl_pkg::ctrl_t  ctrl_o
);
  import pfl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (!flags_i.cmd_free && !flags_i.head_zero) begin
          state_d = S_POP;
        end else if (!flags_i.cmd_free && !flags_i.full) begin
          state_d = S_GROW;
        end else begin
          state_d = S_DONE;
        end
      end
      S_GROW: begin
        if (flags_i.grow_last) state_d = S_READ;
      end
      S_READ:  state_d = S_POP;
      S_POP:   state_d = S_DONE;
      S_DONE: begin
        if (flags_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o           = 1'b0;
    ctrl_o               = '0;
    ctrl_o.addr_sel      = ADDR_HEAD;
    ctrl_o.res_status    = ST_OK;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
      end
      S_DECODE: begin
        if (!flags_i.cmd_free) begin
          if (flags_i.head_zero) begin
            if (flags_i.full) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = ST_FULL;
            end else begin
              ctrl_o.grow_start = 1'b1;
            end
          end
          // non-empty list: address already on head, read lands next cycle
        end else begin
          ctrl_o.res_load = 1'b1;
          if (flags_i.out_of_range) begin
            ctrl_o.res_status = ST_RANGE;
          end else if (flags_i.is_head) begin
            ctrl_o.res_status = ST_HEAD;
          end else begin
            ctrl_o.addr_sel       = ADDR_PAGE;
            ctrl_o.ram_we         = 1'b1;
            ctrl_o.head_from_page = 1'b1;
          end
        end
      end
      S_GROW: begin
        ctrl_o.addr_sel    = ADDR_GROW;
        ctrl_o.ram_we      = 1'b1;
        ctrl_o.wdata_grow  = 1'b1;
        ctrl_o.grow_step   = 1'b1;
        ctrl_o.grow_commit = flags_i.grow_last;
      end
      S_READ: begin
        ctrl_o.addr_sel = ADDR_HEAD;
      end
      S_POP: begin
        ctrl_o.head_from_ram = 1'b1;
        ctrl_o.res_load      = 1'b1;
        ctrl_o.res_page_head = 1'b1;
      end
      S_DONE: begin
        ctrl_o.out_load = flags_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/page_free_list_allocator.sv]
// Top level: page free-list allocator with link store, chunk growth counter and result register.
//
//  channel  | direction | fields (low bit up)
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tuser: cmd[0]; tdata: page[9:0], zero pad
//  m_axis   | out       | tdata: alloc_page[9:0], status[11:10], zero pad
//
//  A free passes decode and the result step; an allocate from a non-empty list adds the pop;
//  an allocate with growth first writes GROW_PAGES links (one link write per cycle through
//  the single RAM port), then one link read. Full or out-of-range answers go on to the result.
//  Reset clears head (empty list), page count (1) and the sequencer; the
//  link store is not cleared. A stalled result holds the block in its last
//  step and the input stays not ready until the result is taken.
module page_free_list_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [pfl_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,   // page[9:0]
  input  logic [0:0]                          s_axis_tuser_i,   // cmd[0]
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [pfl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o    // alloc_page[9:0], status[11:10]
);
  import pfl_pkg::*;

  flags_t flags;
  ctrl_t  ctrl;

  logic                cmd_q;
  logic [PAGE_W-1:0]   page_q;
  logic [PAGE_W-1:0]   head_q, head_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [PAGE_W-1:0]   grow_pg_q, grow_pg_d;
  logic [GROW_CW-1:0]  grow_k_q, grow_k_d;
  logic [PAGE_W-1:0]   res_page_q;
  status_e             res_status_q;
  logic                out_valid_q, out_valid_d;
  logic [PAGE_W-1:0]   out_page_q;
  status_e             out_status_q;

  logic [PAGE_W-1:0]   grow_inc;
  logic [PAGE_W-1:0]   ram_addr_pg;
  logic [PAGE_W-1:0]   ram_wdata;
  logic [PAGE_W-1:0]   ram_rdata;
  logic [CHK_W-1:0]    grow_end;

  pfl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .flags_i    (flags),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  // shared incrementer: next page in the chunk, also the link value written
  assign grow_inc = grow_pg_q + PAGE_W'(1);
  assign grow_end = {1'b0, count_q} + CHK_W'(GROW_PAGES);

  assign flags.cmd_free     = (cmd_q == CMD_FREE);
  assign flags.head_zero    = (head_q == '0);
  assign flags.full         = (grow_end > CHK_W'(MAX_PAGES));
  assign flags.out_of_range = (page_q == '0) || ({1'b0, page_q} >= count_q);
  assign flags.is_head      = (page_q == head_q);
  assign flags.grow_last    = (grow_k_q == GROW_CW'(GROW_PAGES - 1));
  assign flags.out_free     = !out_valid_q || m_axis_tready_i;

  always_comb begin
    case (ctrl.addr_sel)
      ADDR_HEAD: ram_addr_pg = head_q;
      ADDR_PAGE: ram_addr_pg = page_q;
      ADDR_GROW: ram_addr_pg = grow_pg_q;
      default:   ram_addr_pg = head_q;
    endcase
  end

  // last page of a chunk ends the list
  assign ram_wdata = ctrl.wdata_grow ? (flags.grow_last ? '0 : grow_inc) : head_q;

  pfl_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.ram_we),
    .addr_i  (LINK_AW'(ram_addr_pg)),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d = head_q;
    if (ctrl.head_from_page) begin
      head_d = page_q;
    end else if (ctrl.grow_commit) begin
      head_d = count_q[PAGE_W-1:0];
    end else if (ctrl.head_from_ram) begin
      head_d = ram_rdata;
    end
  end

  assign count_d = ctrl.grow_commit ? grow_end[COUNT_W-1:0] : count_q;

  always_comb begin
    grow_pg_d = grow_pg_q;
    grow_k_d  = grow_k_q;
    if (ctrl.grow_start) begin
      grow_pg_d = count_q[PAGE_W-1:0];
      grow_k_d  = '0;
    end else if (ctrl.grow_step) begin
      grow_pg_d = grow_inc;
      grow_k_d  = grow_k_q + GROW_CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= COUNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      cmd_q  <= s_axis_tuser_i[0];
      page_q <= s_axis_tdata_i[PAGE_W-1:0];
    end
    grow_pg_q <= grow_pg_d;
    grow_k_q  <= grow_k_d;
    if (ctrl.res_load) begin
      res_page_q   <= ctrl.res_page_head ? head_q : '0;
      res_status_q <= ctrl.res_status;
    end
    if (ctrl.out_load) begin
      out_page_q   <= res_page_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - PAGE_W - STATUS_W){1'b0}},
                            out_status_q, out_page_q};

endmodule

[tb/tb_page_free_list_allocator.sv]
// Self-checking testbench for the page free-list allocator: directed, random and stress traffic.
module tb_page_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import pfl_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 360;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [PAGE_W-1:0] page;
    status_e           status;
  } page_result_t;

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;   // page[9:0], zero pad
  logic [0:0]             s_axis_tuser_i  = '0;   // cmd[0]
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;         // alloc_page[9:0], status[11:10], zero pad

  // predicted allocator state
  int                pred_head  = 0;
  int                pred_count = 1;
  logic [PAGE_W-1:0] pred_link [MAX_PAGES];
  int                pages_in_use[$];

  page_result_t expected_results[$];

  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int input_stalls   = 0;
  int grow_events    = 0;
  int status_seen [4];

  page_result_t      want;
  logic [PAGE_W-1:0] got_page;
  status_e           got_status;

  page_free_list_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, what);
  endfunction

  // Computes the answer to one request and advances the predicted list.
  function automatic page_result_t predict_request(logic cmd, logic [PAGE_W-1:0] page);
    page_result_t res;
    int k;
    res.page   = '0;
    res.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      if (pred_head == 0) begin
        if (pred_count + GROW_PAGES > MAX_PAGES) begin
          res.status = ST_FULL;
          return res;
        end
        for (k = 0; k < GROW_PAGES; k++)
          pred_link[pred_count + k] = (k == GROW_PAGES - 1) ? '0 : PAGE_W'(pred_count + k + 1);
        pred_head  = pred_count;
        pred_count = pred_count + GROW_PAGES;
        grow_events++;
      end
      res.page  = PAGE_W'(pred_head);
      pred_head = pred_link[pred_head];
    end else if (page == 0 || page >= pred_count) begin
      res.status = ST_RANGE;
    end else if (page == pred_head) begin
      res.status = ST_HEAD;
    end else begin
      pred_link[page] = PAGE_W'(pred_head);
      pred_head       = page;
    end
    return res;
  endfunction

  // a free that would push a page already sitting in the list (makes a cycle)
  function automatic bit is_double_free(logic [PAGE_W-1:0] page);
    if (page == 0 || page >= pred_count || page == pred_head) return 1'b0;
    foreach (pages_in_use[i])
      if (pages_in_use[i] == page) return 1'b0;
    return 1'b1;
  endfunction

  // Must be entered at a rising edge; returns at the edge the word is taken.
  task automatic send_req(input logic cmd, input logic [PAGE_W-1:0] page);
    page_result_t res;
    int idx;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(IN_TDATA_W-PAGE_W){1'b0}}, page};
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      input_stalls++;
      @(posedge clk_i);
    end
    words_sent++;
    res = predict_request(cmd, page);
    expected_results.push_back(res);
    if (res.status == ST_OK) begin
      if (cmd == CMD_ALLOC) begin
        pages_in_use.push_back(int'(res.page));
      end else begin
        idx = -1;
        foreach (pages_in_use[i])
          if (idx < 0 && pages_in_use[i] == page) idx = i;
        if (idx >= 0) pages_in_use.delete(idx);
      end
    end
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_page   = m_axis_tdata_o[PAGE_W-1:0];
      got_status = status_e'(m_axis_tdata_o[PAGE_W +: STATUS_W]);
      results_seen++;
      status_seen[got_status]++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: page %0d status %s",
                                got_page, got_status.name()));
      end else begin
        want = expected_results.pop_front();
        if (got_page !== want.page)
          flag_mismatch($sformatf("alloc_page: expected %0d, got %0d", want.page, got_page));
        if (got_status !== want.status)
          flag_mismatch($sformatf("status: expected %s, got %s (expected page %0d)",
                                  want.status.name(), got_status.name(), want.page));
      end
    end
  end

  // header page, pages never grown, top of the page range
  task automatic test_range_errors();
    send_req(CMD_FREE, '0);
    send_req(CMD_FREE, PAGE_W'(5));
    send_req(CMD_FREE, '1);
  endtask

  task automatic test_growth_and_reuse();
    send_req(CMD_ALLOC, '1);           // first chunk
    send_req(CMD_FREE, PAGE_W'(pred_head));
    send_req(CMD_ALLOC, '0);
    send_req(CMD_ALLOC, '0);
    send_req(CMD_FREE, PAGE_W'(2));
    send_req(CMD_FREE, PAGE_W'(1));
    while (pred_head != 0) send_req(CMD_ALLOC, '0);
    send_req(CMD_ALLOC, '0);           // second chunk
    send_req(CMD_FREE, PAGE_W'(pred_count));
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int pick;
    logic [PAGE_W-1:0] page;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_req(CMD_ALLOC, PAGE_W'($urandom_range(1023)));
        end else if (pick < 85 && pages_in_use.size() > 0) begin
          send_req(CMD_FREE, PAGE_W'(pages_in_use[$urandom_range(pages_in_use.size() - 1)]));
        end else begin
          case ($urandom_range(3))
            0: page = '0;
            1: page = PAGE_W'(pred_head);
            2: page = (pred_count < MAX_PAGES) ?
                      PAGE_W'($urandom_range(MAX_PAGES - 1, pred_count)) : '1;
            default: begin
              page = PAGE_W'($urandom_range(1023));
              if (is_double_free(page)) page = PAGE_W'(pred_head);
            end
          endcase
          send_req(CMD_FREE, page);
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    int n;
    wait_results_drained();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_left    <= HOLD_CYCLES;
    for (n = 0; n < 20; n++) begin
      if (n % 3 == 2 && pages_in_use.size() > 0)
        send_req(CMD_FREE, PAGE_W'(pages_in_use[$urandom_range(pages_in_use.size() - 1)]));
      else
        send_req(CMD_ALLOC, '0);
    end
    wait_results_drained();
  endtask

  // empty the list, then free pages at the top of the grown range and elsewhere, and empty it again
  task automatic test_capacity();
    int n;
    src_idle_pct  = 30;
    snk_stall_pct = 30;
    while (pred_head != 0)
      send_req(CMD_ALLOC, PAGE_W'($urandom_range(1023)));
    send_req(CMD_FREE, PAGE_W'(pred_count));
    send_req(CMD_FREE, '1);
    send_req(CMD_FREE, PAGE_W'(pred_count - 1));
    send_req(CMD_FREE, PAGE_W'(512));
    send_req(CMD_FREE, PAGE_W'(1));
    send_req(CMD_FREE, PAGE_W'(pred_head));
    for (n = 0; n < 8; n++)
      send_req(CMD_FREE, PAGE_W'(pages_in_use[$urandom_range(pages_in_use.size() - 1)]));
    while (pred_head != 0) send_req(CMD_ALLOC, '0);
  endtask

  // list is empty here; re-freeing a deeper page closes a two-page loop
  task automatic test_double_free();
    send_req(CMD_FREE, PAGE_W'(5));
    send_req(CMD_FREE, PAGE_W'(10));
    send_req(CMD_FREE, PAGE_W'(5));
    repeat (5) send_req(CMD_ALLOC, '0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_range_errors();
    test_growth_and_reuse();
    test_random_traffic();
    test_backpressure();
    test_capacity();
    test_double_free();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) flag_mismatch("results still outstanding at end");

    $display("Sent %0d words, checked %0d results; %0d chunk growths, %0d input stall cycles",
             words_sent, results_seen, grow_events, input_stalls);
    $display("Status mix: ok %0d, full %0d, head %0d, range %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_HEAD],
             status_seen[ST_RANGE], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[page_free_list_allocator.f]
rtl/pfl_pkg.sv
rtl/pfl_ram.sv
rtl/pfl_seq.sv
rtl/page_free_list_allocator.sv
tb/tb_page_free_list_allocator.sv
